### sv/srec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_pkg
// shared types, constants and helper functions for the s-record decoder
// ----------------------------------------------------------------------------
package srec_pkg;

    // address bits kept from a record (16 to 32)
    localparam int ADDR_WIDTH     = 32;
    // width of the address fields on the result channel
    localparam int OUT_ADDR_WIDTH = 32;

    localparam logic [7:0] CHAR_S   = 8'h53;
    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] SUM_GOOD = 8'hff;

    localparam logic [3:0] TYPE_LAST_DATA = 4'd3;
    localparam logic [3:0] TYPE_BAD_A     = 4'd4;
    localparam logic [3:0] TYPE_BAD_B     = 4'd6;
    localparam logic [3:0] TYPE_MAX       = 4'd9;

    typedef enum logic [3:0] {
        PH_START,
        PH_SKIP,
        PH_TYPE,
        PH_BAD,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SUM,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic                      write_valid;
        logic [OUT_ADDR_WIDTH-1:0] write_address;
        logic [7:0]                write_byte;
        logic                      line_end;
        logic                      line_error;
        logic [OUT_ADDR_WIDTH-1:0] start_address;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    // ascii hex digit decode, nibble 0 for anything else
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.nib = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.nib = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.nib = 4'(c - 8'h41 + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // address length in bytes for a record type
    function automatic logic [2:0] addr_len(input logic [3:0] t);
        logic [2:0] len;
        if (t == 4'd0)
        begin
            len = 3'd2;
        end
        else if (t <= TYPE_LAST_DATA)
        begin
            len = 3'(t + 4'd1);
        end
        else if (t == 4'd5)
        begin
            len = 3'd2;
        end
        else
        begin
            len = 3'(4'd11 - t);
        end
        return len;
    endfunction

endpackage
`default_nettype wire

### sv/srec_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_line_state
// per-character line state and the result of one character
// ----------------------------------------------------------------------------
module srec_line_state (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire srec_pkg::in_item_t item,
    output srec_pkg::out_item_t     result
);
    import srec_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [3:0]            type_reg, type_next;
    logic [3:0]            high_reg, high_next;
    logic                  parity_reg, parity_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            count_reg, count_next;
    logic [7:0]            left_reg, left_next;
    logic [7:0]            index_reg, index_next;
    logic [ADDR_WIDTH-1:0] raddr_reg, raddr_next;
    logic                  bad_reg, bad_next;
    logic [ADDR_WIDTH-1:0] start_reg, start_next;

    hex_t                  hex;
    logic [7:0]            byte_val;
    logic [7:0]            al_plus1;
    logic                  is_eol;
    logic                  in_record;
    logic                  wv;
    logic [ADDR_WIDTH-1:0] wa;
    logic                  lerr;

    assign hex       = hex_decode(item.ch);
    assign byte_val  = {high_reg, hex.nib};
    assign al_plus1  = 8'(addr_len(type_reg)) + 8'd1;
    assign is_eol    = (item.ch == CHAR_CR) || (item.ch == CHAR_LF);
    assign in_record = (phase_reg == PH_COUNT) || (phase_reg == PH_ADDR) ||
                       (phase_reg == PH_DATA) || (phase_reg == PH_SUM);

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        high_next   = high_reg;
        parity_next = parity_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        index_next  = index_reg;
        raddr_next  = raddr_reg;
        bad_next    = bad_reg;
        start_next  = start_reg;
        wv          = 1'b0;
        wa          = '0;
        lerr        = 1'b0;

        priority if (item.action)
        begin
            start_next = '0;
        end
        else if (is_eol)
        begin
            if (phase_reg == PH_BAD || in_record)
            begin
                lerr = 1'b1;
            end
            else if (phase_reg == PH_DONE)
            begin
                if (bad_reg || sum_reg != SUM_GOOD)
                begin
                    lerr = 1'b1;
                end
                else if (start_reg == '0)
                begin
                    start_next = raddr_reg;
                end
            end
            phase_next = PH_START;
        end
        else if (phase_reg == PH_START)
        begin
            if (item.ch == CHAR_S)
            begin
                phase_next  = PH_TYPE;
                sum_next    = '0;
                bad_next    = 1'b0;
                parity_next = 1'b0;
                high_next   = '0;
                raddr_next  = '0;
                count_next  = '0;
                left_next   = '0;
                index_next  = '0;
            end
            else
            begin
                phase_next = PH_SKIP;
            end
        end
        else if (phase_reg == PH_TYPE)
        begin
            if (!hex.ok || hex.nib > TYPE_MAX)
            begin
                phase_next = PH_SKIP;
            end
            else
            begin
                type_next  = hex.nib;
                phase_next = (hex.nib == TYPE_BAD_A || hex.nib == TYPE_BAD_B) ?
                             PH_BAD : PH_COUNT;
            end
        end
        else if (in_record)
        begin
            if (!hex.ok)
            begin
                bad_next = 1'b1;
            end
            if (!parity_reg)
            begin
                high_next   = hex.nib;
                parity_next = 1'b1;
            end
            else
            begin
                parity_next = 1'b0;
                sum_next    = sum_reg + byte_val;
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        count_next = byte_val;
                        left_next  = 8'(addr_len(type_reg));
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        raddr_next = {raddr_reg[ADDR_WIDTH-9:0], byte_val};
                        left_next  = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            index_next = '0;
                            if (type_reg <= TYPE_LAST_DATA && count_reg > al_plus1)
                            begin
                                left_next  = count_reg - al_plus1;
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                left_next  = '0;
                                phase_next = PH_SUM;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (!bad_next)
                        begin
                            wv = 1'b1;
                            wa = raddr_reg + ADDR_WIDTH'(index_reg);
                        end
                        index_next = index_reg + 8'd1;
                        left_next  = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // skip, bad and done phases ignore ordinary characters

    always_comb
    begin
        result.write_valid   = wv;
        result.write_address = OUT_ADDR_WIDTH'(wa);
        result.write_byte    = wv ? byte_val : 8'd0;
        result.line_end      = !item.action && is_eol;
        result.line_error    = lerr;
        result.start_address = OUT_ADDR_WIDTH'(start_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            type_reg   <= '0;
            high_reg   <= '0;
            parity_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
            left_reg   <= '0;
            index_reg  <= '0;
            raddr_reg  <= '0;
            bad_reg    <= 1'b0;
            start_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            high_reg   <= high_next;
            parity_reg <= parity_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            index_reg  <= index_next;
            raddr_reg  <= raddr_next;
            bad_reg    <= bad_next;
            start_reg  <= start_next;
        end
    end

endmodule
`default_nettype wire

### sv/srec_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srec_out_reg
// result register with valid/ready hold toward the receiver
// ----------------------------------------------------------------------------
module srec_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire srec_pkg::out_item_t result_in,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output srec_pkg::out_item_t      result
);
    import srec_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule
`default_nettype wire

### sv/srecord_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srecord_stream_decoder
// streaming motorola s-record decoder, one ascii character per transfer
// ----------------------------------------------------------------------------
// usage
//   item channel: one character (or a clear of the start address) per
//   transfer on item_valid/item_ready
//   result channel: exactly one result per item on result_valid/result_ready,
//   carrying the data byte write, line end, line error and start address
//   path: an item taken goes into the input register, then is decoded
//   into the result register once that register is free or emptying
//   throughput: one item per cycle while the receiver keeps taking results;
//   the line state updates as an item moves from input to result register
//   stall: while the receiver holds result_ready low the result register
//   holds, the input register still takes one more item, then item_ready
//   drops until the result is taken
//   reset: both registers empty, decoder waits for 'S' at line start and the
//   remembered start address is zero
// ----------------------------------------------------------------------------
module srecord_stream_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire srec_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output srec_pkg::out_item_t      result
);
    import srec_pkg::*;

    // input register
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;

    // an item moves into decode when the result register is free or emptying
    logic      advance;
    out_item_t step_result;

    assign advance    = in_valid_reg && (!result_valid || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload register, loaded on each item transfer
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
    end

    // line state and per-character result
    srec_line_state u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (step_result)
    );

    // result register toward the receiver
    srec_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .result_in    (step_result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire
